// ===== rtl/core/sfcs_pkg.sv =====
// shared types and codes of the spi flash command sequencer
`timescale 1ns / 1ps

package sfcs_pkg;

    localparam int LEN_W = 25;
    localparam int IN_ADDR_W = 24;

    // input beat actions
    localparam logic [1:0] ACT_COMMAND = 2'd0;
    localparam logic [1:0] ACT_WRITE   = 2'd1;
    localparam logic [1:0] ACT_REPLY   = 2'd2;

    // host commands
    localparam logic [2:0] CMD_READ_ID      = 3'd0;
    localparam logic [2:0] CMD_WRITE        = 3'd1;
    localparam logic [2:0] CMD_SECTOR_ERASE = 3'd2;
    localparam logic [2:0] CMD_BLOCK_ERASE  = 3'd3;
    localparam logic [2:0] CMD_CHIP_ERASE   = 3'd4;
    localparam logic [2:0] CMD_READ         = 3'd5;

    // result kinds
    localparam logic [2:0] KIND_SPI     = 3'd0;
    localparam logic [2:0] KIND_RELEASE = 3'd1;
    localparam logic [2:0] KIND_READ    = 3'd2;
    localparam logic [2:0] KIND_ID      = 3'd3;
    localparam logic [2:0] KIND_WANT    = 3'd4;
    localparam logic [2:0] KIND_DONE    = 3'd5;

    // register indexes
    localparam logic [2:0] REG_READ_ID      = 3'd0;
    localparam logic [2:0] REG_WRITE_ENABLE = 3'd1;
    localparam logic [2:0] REG_READ_STATUS  = 3'd2;
    localparam logic [2:0] REG_PAGE_PROGRAM = 3'd3;
    localparam logic [2:0] REG_SECTOR_ERASE = 3'd4;
    localparam logic [2:0] REG_BLOCK_ERASE  = 3'd5;
    localparam logic [2:0] REG_CHIP_ERASE   = 3'd6;
    localparam logic [2:0] REG_READ_DATA    = 3'd7;

    localparam logic [7:0] DUMMY_BYTE = 8'hFF;

    typedef enum logic [8:0] {
        PH_IDLE    = 9'b000000001,
        PH_WREN    = 9'b000000010,
        PH_ADDR    = 9'b000000100,
        PH_WANT    = 9'b000001000,
        PH_DATA    = 9'b000010000,
        PH_POLL_OP = 9'b000100000,
        PH_POLL    = 9'b001000000,
        PH_READ    = 9'b010000000,
        PH_ID      = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  spi_byte;
        logic [7:0]  host_byte;
        logic [7:0]  maker_id;
        logic [15:0] device_id;
        logic        last;
    } result_t;

endpackage

// ===== rtl/core/spi_flash_command_sequencer_top.sv =====
// spi nor flash command sequencer: host commands to flash byte sequences
// an accepted beat is registered in the input register, then its results in the result buffer
// throughput: 1 beat per cycle where each beat gives one result and m_ready is high; a
// beat with more results holds the input side until its last is taken (3-entry result buffer)
// reset: aresetn synchronous active low, phase idle, opcodes to standard values
`timescale 1ns / 1ps

module spi_flash_command_sequencer_top
    import sfcs_pkg::*;
#(
    parameter int PAGE_BYTES   = 256,
    parameter int ADDRESS_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_action,
    input  logic [2:0]           s_command,
    input  logic [IN_ADDR_W-1:0] s_address,
    input  logic [LEN_W-1:0]     s_length,
    input  logic [7:0]           s_data_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_kind,
    output logic [7:0]           m_spi_byte,
    output logic [7:0]           m_host_byte,
    output logic [7:0]           m_maker_id,
    output logic [15:0]          m_device_id,
    output logic                 m_last
);

    // page size is a power of two
    localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
    localparam int PL_W       = PAGE_BITS + 1;
    localparam int ADDR_BYTES = (ADDRESS_BITS + 7) / 8;
    localparam int AB_IDX_W   = (ADDR_BYTES > 1) ? $clog2(ADDR_BYTES) : 1;

    // configuration registers
    logic [7:0] op_read_id_reg, op_wren_reg, op_status_reg, op_program_reg;
    logic [7:0] op_sector_reg, op_block_reg, op_chip_reg, op_read_reg;
    logic       cfg_write;
    logic [7:0] cfg_rd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_read_id_reg <= 8'h9F;
            op_wren_reg    <= 8'h06;
            op_status_reg  <= 8'h05;
            op_program_reg <= 8'h02;
            op_sector_reg  <= 8'h20;
            op_block_reg   <= 8'hD8;
            op_chip_reg    <= 8'hC7;
            op_read_reg    <= 8'h03;
        end else if (cfg_write) begin
            unique case (paddr[4:2])
                REG_READ_ID:      op_read_id_reg <= pwdata[7:0];
                REG_WRITE_ENABLE: op_wren_reg    <= pwdata[7:0];
                REG_READ_STATUS:  op_status_reg  <= pwdata[7:0];
                REG_PAGE_PROGRAM: op_program_reg <= pwdata[7:0];
                REG_SECTOR_ERASE: op_sector_reg  <= pwdata[7:0];
                REG_BLOCK_ERASE:  op_block_reg   <= pwdata[7:0];
                REG_CHIP_ERASE:   op_chip_reg    <= pwdata[7:0];
                REG_READ_DATA:    op_read_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_READ_ID:      cfg_rd = op_read_id_reg;
            REG_WRITE_ENABLE: cfg_rd = op_wren_reg;
            REG_READ_STATUS:  cfg_rd = op_status_reg;
            REG_PAGE_PROGRAM: cfg_rd = op_program_reg;
            REG_SECTOR_ERASE: cfg_rd = op_sector_reg;
            REG_BLOCK_ERASE:  cfg_rd = op_block_reg;
            REG_CHIP_ERASE:   cfg_rd = op_chip_reg;
            REG_READ_DATA:    cfg_rd = op_read_reg;
            default:          cfg_rd = 8'h00;
        endcase
    end

    assign prdata = {24'd0, cfg_rd};

    // input register
    logic                 in_valid_reg;
    logic [1:0]           in_action_reg;
    logic [2:0]           in_command_reg;
    logic [IN_ADDR_W-1:0] in_address_reg;
    logic [LEN_W-1:0]     in_length_reg;
    logic [7:0]           in_data_reg;
    logic                 consume;

    // sequencer state
    phase_t                  phase_reg, phase_next;
    logic [2:0]              cmd_reg, cmd_next;
    logic [ADDRESS_BITS-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]        rem_reg, rem_next;
    logic [PL_W-1:0]         page_left_reg, page_left_next;
    logic [2:0]              step_reg, step_next;
    logic [23:0]             id_reg, id_next;

    // result buffer
    result_t    res_buf_reg [3];
    logic [1:0] buf_cnt_reg, buf_idx_reg;
    logic       buf_free, out_pop;

    result_t                   res [3];
    logic [1:0]                res_n;
    logic [ADDRESS_BITS-1:0]   addr_in;
    logic [PL_W-1:0]           room_in, room_cur, page_in, page_cur;
    logic [2:0]                addr_count, step_inc;
    logic [AB_IDX_W-1:0]       byte_sel;
    logic [ADDR_BYTES*8-1:0]   addr_ext;
    logic [ADDR_BYTES-1:0][7:0] addr_bytes;
    logic [7:0]                erase_op;
    logic [LEN_W-1:0]          rem_dec;
    logic [23:0]               id_shift;

    assign m_valid  = (buf_cnt_reg != 2'd0);
    assign out_pop  = m_valid && m_ready;
    assign buf_free = (buf_cnt_reg == 2'd0) || (out_pop && (buf_idx_reg == buf_cnt_reg - 2'd1));
    assign consume  = in_valid_reg && buf_free;
    assign s_ready  = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg  <= s_action;
            in_command_reg <= s_command;
            in_address_reg <= s_address;
            in_length_reg  <= s_length;
            in_data_reg    <= s_data_byte;
        end
    end

    // page room from an address, clipped to the bytes still to write
    assign addr_in  = ADDRESS_BITS'(32'(in_address_reg));
    assign room_in  = PL_W'(PAGE_BYTES) - PL_W'(addr_in[PAGE_BITS-1:0]);
    assign room_cur = PL_W'(PAGE_BYTES) - PL_W'(addr_reg[PAGE_BITS-1:0]);
    assign page_in  = (in_length_reg < LEN_W'(room_in)) ? PL_W'(in_length_reg) : room_in;
    assign page_cur = (rem_reg < LEN_W'(room_cur)) ? PL_W'(rem_reg) : room_cur;

    // address bytes go out most significant first
    assign addr_count = (cmd_reg == CMD_CHIP_ERASE) ? 3'd0 : 3'(ADDR_BYTES);
    assign byte_sel   = AB_IDX_W'(3'(ADDR_BYTES - 1) - step_reg);
    assign addr_ext   = (ADDR_BYTES * 8)'(addr_reg);
    assign addr_bytes = addr_ext;
    assign rem_dec    = rem_reg - LEN_W'(1);
    assign step_inc   = step_reg + 3'd1;
    assign id_shift   = {id_reg[15:0], in_data_reg};

    always_comb begin
        case (cmd_reg)
            CMD_SECTOR_ERASE: erase_op = op_sector_reg;
            CMD_BLOCK_ERASE:  erase_op = op_block_reg;
            CMD_CHIP_ERASE:   erase_op = op_chip_reg;
            default:          erase_op = op_program_reg;
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        rem_next       = rem_reg;
        page_left_next = page_left_reg;
        step_next      = step_reg;
        id_next        = id_reg;
        res_n          = 2'd0;
        for (int i = 0; i < 3; i++) begin
            res[i] = '0;
        end

        unique case (phase_reg)
            PH_IDLE: begin
                if (in_action_reg == ACT_COMMAND) begin
                    cmd_next  = in_command_reg;
                    addr_next = addr_in;
                    rem_next  = in_length_reg;
                    step_next = 3'd0;
                    res_n     = 2'd1;
                    case (in_command_reg) inside
                        CMD_READ_ID: begin
                            id_next          = 24'd0;
                            res[0].kind      = KIND_SPI;
                            res[0].spi_byte  = op_read_id_reg;
                            phase_next       = PH_ID;
                        end
                        CMD_WRITE: begin
                            if (in_length_reg == '0) begin
                                res[0].kind = KIND_DONE;
                            end else begin
                                page_left_next  = page_in;
                                res[0].kind     = KIND_SPI;
                                res[0].spi_byte = op_wren_reg;
                                phase_next      = PH_WREN;
                            end
                        end
                        CMD_SECTOR_ERASE, CMD_BLOCK_ERASE, CMD_CHIP_ERASE: begin
                            res[0].kind     = KIND_SPI;
                            res[0].spi_byte = op_wren_reg;
                            phase_next      = PH_WREN;
                        end
                        CMD_READ: begin
                            res[0].kind     = KIND_SPI;
                            res[0].spi_byte = op_read_reg;
                            phase_next      = PH_ADDR;
                        end
                        default: res[0].kind = KIND_DONE;
                    endcase
                end
            end
            PH_WANT: begin
                if (in_action_reg == ACT_WRITE) begin
                    res_n           = 2'd1;
                    res[0].kind     = KIND_SPI;
                    res[0].spi_byte = in_data_reg;
                    phase_next      = PH_DATA;
                end
            end
            PH_ID: begin
                if (in_action_reg == ACT_REPLY) begin
                    if (step_reg == 3'd0) begin
                        step_next       = 3'd1;
                        res_n           = 2'd1;
                        res[0].kind     = KIND_SPI;
                        res[0].spi_byte = DUMMY_BYTE;
                    end else begin
                        id_next   = id_shift;
                        step_next = step_inc;
                        if (step_inc < 3'd4) begin
                            res_n           = 2'd1;
                            res[0].kind     = KIND_SPI;
                            res[0].spi_byte = DUMMY_BYTE;
                        end else begin
                            res_n            = 2'd3;
                            res[0].kind      = KIND_RELEASE;
                            res[1].kind      = KIND_ID;
                            res[1].maker_id  = id_shift[23:16];
                            res[1].device_id = id_shift[15:0];
                            res[2].kind      = KIND_DONE;
                            phase_next       = PH_IDLE;
                            step_next        = 3'd0;
                        end
                    end
                end
            end
            PH_WREN: begin
                if (in_action_reg == ACT_REPLY) begin
                    res_n           = 2'd2;
                    res[0].kind     = KIND_RELEASE;
                    res[1].kind     = KIND_SPI;
                    res[1].spi_byte = erase_op;
                    step_next       = 3'd0;
                    phase_next      = PH_ADDR;
                end
            end
            PH_ADDR: begin
                if (in_action_reg == ACT_REPLY) begin
                    if (step_reg < addr_count) begin
                        res_n           = 2'd1;
                        res[0].kind     = KIND_SPI;
                        res[0].spi_byte = addr_bytes[byte_sel];
                        step_next       = step_inc;
                    end else if (cmd_reg == CMD_WRITE) begin
                        res_n       = 2'd1;
                        res[0].kind = KIND_WANT;
                        phase_next  = PH_WANT;
                    end else if (cmd_reg == CMD_READ) begin
                        if (rem_reg != '0) begin
                            res_n           = 2'd1;
                            res[0].kind     = KIND_SPI;
                            res[0].spi_byte = DUMMY_BYTE;
                            phase_next      = PH_READ;
                        end else begin
                            res_n       = 2'd2;
                            res[0].kind = KIND_RELEASE;
                            res[1].kind = KIND_DONE;
                            phase_next  = PH_IDLE;
                        end
                    end else begin
                        res_n           = 2'd2;
                        res[0].kind     = KIND_RELEASE;
                        res[1].kind     = KIND_SPI;
                        res[1].spi_byte = op_status_reg;
                        phase_next      = PH_POLL_OP;
                    end
                end
            end
            PH_DATA: begin
                if (in_action_reg == ACT_REPLY) begin
                    page_left_next = page_left_reg - PL_W'(1);
                    rem_next       = rem_dec;
                    addr_next      = addr_reg + ADDRESS_BITS'(1);
                    if (page_left_reg != PL_W'(1)) begin
                        res_n       = 2'd1;
                        res[0].kind = KIND_WANT;
                        phase_next  = PH_WANT;
                    end else begin
                        res_n           = 2'd2;
                        res[0].kind     = KIND_RELEASE;
                        res[1].kind     = KIND_SPI;
                        res[1].spi_byte = op_status_reg;
                        phase_next      = PH_POLL_OP;
                    end
                end
            end
            PH_POLL_OP: begin
                if (in_action_reg == ACT_REPLY) begin
                    res_n           = 2'd1;
                    res[0].kind     = KIND_SPI;
                    res[0].spi_byte = DUMMY_BYTE;
                    phase_next      = PH_POLL;
                end
            end
            PH_POLL: begin
                if (in_action_reg == ACT_REPLY) begin
                    if (in_data_reg[0]) begin
                        // still busy
                        res_n           = 2'd1;
                        res[0].kind     = KIND_SPI;
                        res[0].spi_byte = DUMMY_BYTE;
                    end else if (cmd_reg == CMD_WRITE && rem_reg != '0) begin
                        page_left_next  = page_cur;
                        res_n           = 2'd2;
                        res[0].kind     = KIND_RELEASE;
                        res[1].kind     = KIND_SPI;
                        res[1].spi_byte = op_wren_reg;
                        phase_next      = PH_WREN;
                    end else begin
                        res_n       = 2'd2;
                        res[0].kind = KIND_RELEASE;
                        res[1].kind = KIND_DONE;
                        phase_next  = PH_IDLE;
                    end
                end
            end
            PH_READ: begin
                if (in_action_reg == ACT_REPLY) begin
                    res[0].kind      = KIND_READ;
                    res[0].host_byte = in_data_reg;
                    rem_next         = rem_dec;
                    addr_next        = addr_reg + ADDRESS_BITS'(1);
                    if (rem_dec != '0) begin
                        res_n           = 2'd2;
                        res[1].kind     = KIND_SPI;
                        res[1].spi_byte = DUMMY_BYTE;
                    end else begin
                        res_n       = 2'd3;
                        res[1].kind = KIND_RELEASE;
                        res[2].kind = KIND_DONE;
                        phase_next  = PH_IDLE;
                    end
                end
            end
            default: phase_next = PH_IDLE;
        endcase

        for (int i = 0; i < 3; i++) begin
            res[i].last = (2'(i) == res_n - 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            cmd_reg       <= '0;
            addr_reg      <= '0;
            rem_reg       <= '0;
            page_left_reg <= '0;
            step_reg      <= '0;
            id_reg        <= '0;
        end else if (consume) begin
            phase_reg     <= phase_next;
            cmd_reg       <= cmd_next;
            addr_reg      <= addr_next;
            rem_reg       <= rem_next;
            page_left_reg <= page_left_next;
            step_reg      <= step_next;
            id_reg        <= id_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_cnt_reg <= 2'd0;
            buf_idx_reg <= 2'd0;
        end else if (consume) begin
            buf_cnt_reg <= res_n;
            buf_idx_reg <= 2'd0;
        end else if (out_pop) begin
            if (buf_idx_reg == buf_cnt_reg - 2'd1) begin
                buf_cnt_reg <= 2'd0;
                buf_idx_reg <= 2'd0;
            end else begin
                buf_idx_reg <= buf_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (consume) begin
            for (int i = 0; i < 3; i++) begin
                res_buf_reg[i] <= res[i];
            end
        end
    end

    assign m_kind      = res_buf_reg[buf_idx_reg].kind;
    assign m_spi_byte  = res_buf_reg[buf_idx_reg].spi_byte;
    assign m_host_byte = res_buf_reg[buf_idx_reg].host_byte;
    assign m_maker_id  = res_buf_reg[buf_idx_reg].maker_id;
    assign m_device_id = res_buf_reg[buf_idx_reg].device_id;
    assign m_last      = res_buf_reg[buf_idx_reg].last;

endmodule

// ===== rtl/core/sfcs_checker.sv =====
// port checks of the spi flash command sequencer and their binding
`timescale 1ns / 1ps

module sfcs_checker
    import sfcs_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        pready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_kind,
    input logic [7:0]  m_spi_byte,
    input logic [7:0]  m_host_byte,
    input logic [7:0]  m_maker_id,
    input logic [15:0] m_device_id,
    input logic        m_last
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_spi_byte)
            && $stable(m_host_byte) && $stable(m_maker_id) && $stable(m_device_id)
            && $stable(m_last))
        else $error("result beat changed while stalled");

    // done always closes the results of a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_DONE |-> m_last)
        else $error("done result not marked last");

    // release, id and read bytes are always followed by another result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_RELEASE || m_kind == KIND_ID || m_kind == KIND_READ)
            |-> !m_last)
        else $error("result marked last too early");

    // an id result is followed by done
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_kind == KIND_ID |=> m_valid && m_kind == KIND_DONE)
        else $error("id result not followed by done");

    assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");

endmodule

bind spi_flash_command_sequencer_top sfcs_checker u_sfcs_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .pready     (pready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_kind     (m_kind),
    .m_spi_byte (m_spi_byte),
    .m_host_byte(m_host_byte),
    .m_maker_id (m_maker_id),
    .m_device_id(m_device_id),
    .m_last     (m_last)
);

// ===== test/tb.sv =====
// testbench of the spi flash command sequencer: host and flash sides with a predicting scoreboard
`timescale 1ns / 1ps

module tb;
    import sfcs_pkg::*;

    localparam int PAGE_BYTES    = 256;
    localparam int ADDR_BYTES    = 3;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_BEATS  = 60;
    localparam int REPORT_CAP    = 100;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // holds its own copy of the sequencer state and the expected result beats
    class flash_traffic_scoreboard;
        logic [7:0]  regs [8];
        phase_t      phase;
        logic [2:0]  cur_cmd;
        logic [23:0] cur_addr;
        logic [24:0] remaining;
        logic [8:0]  page_left;
        logic [2:0]  step;
        logic [23:0] id_acc;
        result_t     awaited [$];
        result_t     burst [$];
        int          failures;
        int          checked;

        function new();
            regs[REG_READ_ID]      = 8'h9F;
            regs[REG_WRITE_ENABLE] = 8'h06;
            regs[REG_READ_STATUS]  = 8'h05;
            regs[REG_PAGE_PROGRAM] = 8'h02;
            regs[REG_SECTOR_ERASE] = 8'h20;
            regs[REG_BLOCK_ERASE]  = 8'hD8;
            regs[REG_CHIP_ERASE]   = 8'hC7;
            regs[REG_READ_DATA]    = 8'h03;
            phase     = PH_IDLE;
            cur_cmd   = '0;
            cur_addr  = '0;
            remaining = '0;
            page_left = '0;
            step      = '0;
            id_acc    = '0;
            failures  = 0;
            checked   = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            regs[idx] = value[7:0];
        endfunction

        function void add(logic [2:0] kind, logic [7:0] spi, logic [7:0] host,
                          logic [7:0] maker, logic [15:0] dev);
            result_t r;
            r.kind      = kind;
            r.spi_byte  = spi;
            r.host_byte = host;
            r.maker_id  = maker;
            r.device_id = dev;
            r.last      = 1'b0;
            burst.push_back(r);
        endfunction

        function void load_page();
            int room;
            room = PAGE_BYTES - (int'(cur_addr) % PAGE_BYTES);
            page_left = (int'(remaining) < room) ? 9'(remaining) : 9'(room);
        endfunction

        // advances the state by one accepted beat, returns the number of results it causes
        function int note_beat(logic [1:0] act, logic [2:0] cmd, logic [23:0] addr,
                               logic [24:0] len, logic [7:0] db);
            logic [7:0] op;
            int acount;
            burst.delete();
            if (phase == PH_IDLE) begin
                if (act != ACT_COMMAND) return 0;
                cur_cmd   = cmd;
                cur_addr  = addr;
                remaining = len;
                step      = '0;
                case (cmd)
                    CMD_READ_ID: begin
                        id_acc = '0;
                        add(KIND_SPI, regs[REG_READ_ID], 0, 0, 0);
                        phase = PH_ID;
                    end
                    CMD_WRITE: begin
                        if (len == 0) begin
                            add(KIND_DONE, 0, 0, 0, 0);
                        end else begin
                            load_page();
                            add(KIND_SPI, regs[REG_WRITE_ENABLE], 0, 0, 0);
                            phase = PH_WREN;
                        end
                    end
                    CMD_SECTOR_ERASE, CMD_BLOCK_ERASE, CMD_CHIP_ERASE: begin
                        add(KIND_SPI, regs[REG_WRITE_ENABLE], 0, 0, 0);
                        phase = PH_WREN;
                    end
                    CMD_READ: begin
                        add(KIND_SPI, regs[REG_READ_DATA], 0, 0, 0);
                        phase = PH_ADDR;
                    end
                    default: add(KIND_DONE, 0, 0, 0, 0);
                endcase
            end else if (phase == PH_WANT) begin
                if (act != ACT_WRITE) return 0;
                add(KIND_SPI, db, 0, 0, 0);
                phase = PH_DATA;
            end else begin
                if (act != ACT_REPLY) return 0;
                case (phase)
                    PH_ID: begin
                        if (step == 0) begin
                            step = 3'd1;
                            add(KIND_SPI, DUMMY_BYTE, 0, 0, 0);
                        end else begin
                            id_acc = {id_acc[15:0], db};
                            step   = step + 3'd1;
                            if (step < 4) begin
                                add(KIND_SPI, DUMMY_BYTE, 0, 0, 0);
                            end else begin
                                add(KIND_RELEASE, 0, 0, 0, 0);
                                add(KIND_ID, 0, 0, id_acc[23:16], id_acc[15:0]);
                                add(KIND_DONE, 0, 0, 0, 0);
                                phase = PH_IDLE;
                                step  = '0;
                            end
                        end
                    end
                    PH_WREN: begin
                        case (cur_cmd)
                            CMD_SECTOR_ERASE: op = regs[REG_SECTOR_ERASE];
                            CMD_BLOCK_ERASE:  op = regs[REG_BLOCK_ERASE];
                            CMD_CHIP_ERASE:   op = regs[REG_CHIP_ERASE];
                            default:          op = regs[REG_PAGE_PROGRAM];
                        endcase
                        add(KIND_RELEASE, 0, 0, 0, 0);
                        add(KIND_SPI, op, 0, 0, 0);
                        step  = '0;
                        phase = PH_ADDR;
                    end
                    PH_ADDR: begin
                        acount = (cur_cmd == CMD_CHIP_ERASE) ? 0 : ADDR_BYTES;
                        if (int'(step) < acount) begin
                            add(KIND_SPI, 8'(cur_addr >> (8 * (acount - 1 - int'(step)))),
                                0, 0, 0);
                            step = step + 3'd1;
                        end else if (cur_cmd == CMD_WRITE) begin
                            add(KIND_WANT, 0, 0, 0, 0);
                            phase = PH_WANT;
                        end else if (cur_cmd == CMD_READ) begin
                            if (remaining != 0) begin
                                add(KIND_SPI, DUMMY_BYTE, 0, 0, 0);
                                phase = PH_READ;
                            end else begin
                                add(KIND_RELEASE, 0, 0, 0, 0);
                                add(KIND_DONE, 0, 0, 0, 0);
                                phase = PH_IDLE;
                            end
                        end else begin
                            add(KIND_RELEASE, 0, 0, 0, 0);
                            add(KIND_SPI, regs[REG_READ_STATUS], 0, 0, 0);
                            phase = PH_POLL_OP;
                        end
                    end
                    PH_DATA: begin
                        page_left = page_left - 9'd1;
                        remaining = remaining - 25'd1;
                        cur_addr  = cur_addr + 24'd1;
                        if (page_left != 0) begin
                            add(KIND_WANT, 0, 0, 0, 0);
                            phase = PH_WANT;
                        end else begin
                            add(KIND_RELEASE, 0, 0, 0, 0);
                            add(KIND_SPI, regs[REG_READ_STATUS], 0, 0, 0);
                            phase = PH_POLL_OP;
                        end
                    end
                    PH_POLL_OP: begin
                        add(KIND_SPI, DUMMY_BYTE, 0, 0, 0);
                        phase = PH_POLL;
                    end
                    PH_POLL: begin
                        if (db[0]) begin
                            add(KIND_SPI, DUMMY_BYTE, 0, 0, 0);
                        end else begin
                            add(KIND_RELEASE, 0, 0, 0, 0);
                            if (cur_cmd == CMD_WRITE && remaining != 0) begin
                                load_page();
                                add(KIND_SPI, regs[REG_WRITE_ENABLE], 0, 0, 0);
                                phase = PH_WREN;
                            end else begin
                                add(KIND_DONE, 0, 0, 0, 0);
                                phase = PH_IDLE;
                            end
                        end
                    end
                    PH_READ: begin
                        add(KIND_READ, 0, db, 0, 0);
                        remaining = remaining - 25'd1;
                        cur_addr  = cur_addr + 24'd1;
                        if (remaining != 0) begin
                            add(KIND_SPI, DUMMY_BYTE, 0, 0, 0);
                        end else begin
                            add(KIND_RELEASE, 0, 0, 0, 0);
                            add(KIND_DONE, 0, 0, 0, 0);
                            phase = PH_IDLE;
                        end
                    end
                    default: begin
                        phase = PH_IDLE;
                        return 0;
                    end
                endcase
            end
            if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i]) awaited.push_back(burst[i]);
            return burst.size();
        endfunction

        function void compare(string field, int want, int got);
            if (want != got) begin
                failures++;
                if (failures <= REPORT_CAP)
                    $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            checked++;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= REPORT_CAP)
                    $error("result beat with nothing expected: kind 0x%0h", got.kind);
                return;
            end
            want = awaited.pop_front();
            compare("kind", want.kind, got.kind);
            compare("spi_byte", want.spi_byte, got.spi_byte);
            compare("host_byte", want.host_byte, got.host_byte);
            compare("maker_id", want.maker_id, got.maker_id);
            compare("device_id", want.device_id, got.device_id);
            compare("last", want.last, got.last);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [2:0]  s_command;
    logic [23:0] s_address;
    logic [24:0] s_length;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_kind;
    logic [7:0]  m_spi_byte;
    logic [7:0]  m_host_byte;
    logic [7:0]  m_maker_id;
    logic [15:0] m_device_id;
    logic        m_last;

    flash_traffic_scoreboard traffic = new();
    bit quiet = 1'b0;
    int beats_used = 0;
    int settings = 1;
    int cycles = 0;

    spi_flash_command_sequencer_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_command   (s_command),
        .s_address   (s_address),
        .s_length    (s_length),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_spi_byte  (m_spi_byte),
        .m_host_byte (m_host_byte),
        .m_maker_id  (m_maker_id),
        .m_device_id (m_device_id),
        .m_last      (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL spi_flash_command_sequencer_top");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(99) >= 16);
    end

    // everything settles between edges, so the negedge value is what the next edge takes
    always @(negedge aclk) begin
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.kind      = m_kind;
            got.spi_byte  = m_spi_byte;
            got.host_byte = m_host_byte;
            got.maker_id  = m_maker_id;
            got.device_id = m_device_id;
            got.last      = m_last;
            traffic.check_result(got);
        end
    end

    task automatic issue(input logic [1:0] act, input logic [2:0] cmd,
                         input logic [23:0] addr, input logic [24:0] len,
                         input logic [7:0] db);
        bit ready_seen;
        int produced;
        if (!quiet) begin
            while ($urandom_range(99) < 16) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_command   <= cmd;
        s_address   <= addr;
        s_length    <= len;
        s_data_byte <= db;
        do begin
            @(negedge aclk);
            ready_seen = s_ready;
            @(posedge aclk);
        end while (!ready_seen);
        produced = traffic.note_beat(act, cmd, addr, len, db);
        if (produced > 0) beats_used++;
    endtask

    // the next beat the sequence expects, with random content in every other field
    task automatic follow_up();
        logic [1:0] act;
        act = (traffic.phase == PH_WANT) ? ACT_WRITE : ACT_REPLY;
        issue(act, 3'($urandom), 24'($urandom), 25'($urandom), 8'($urandom));
    endtask

    // a beat of the wrong action for the current phase, which the block must ignore
    task automatic noise();
        logic [1:0] wanted;
        logic [1:0] act;
        if (traffic.phase == PH_IDLE) wanted = ACT_COMMAND;
        else if (traffic.phase == PH_WANT) wanted = ACT_WRITE;
        else wanted = ACT_REPLY;
        do act = 2'($urandom_range(3)); while (act == wanted);
        issue(act, 3'($urandom), 24'($urandom), 25'($urandom), 8'($urandom));
    endtask

    task automatic complete_sequence();
        while (traffic.phase != PH_IDLE) follow_up();
    endtask

    task automatic run_sequence(input logic [2:0] cmd, input logic [23:0] addr,
                                input logic [24:0] len);
        issue(ACT_COMMAND, cmd, addr, len, 8'($urandom));
        complete_sequence();
    endtask

    task automatic start_command();
        logic [2:0]  cmd;
        logic [23:0] addr;
        logic [24:0] len;
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0:       cmd = CMD_READ_ID;
            1, 2, 3: cmd = CMD_WRITE;
            4:       cmd = CMD_SECTOR_ERASE;
            5:       cmd = CMD_BLOCK_ERASE;
            6:       cmd = CMD_CHIP_ERASE;
            7, 8:    cmd = CMD_READ;
            default: cmd = 3'($urandom_range(CMD_READ + 1, 7));
        endcase
        addr = 24'($urandom);
        // some commands start just short of a page boundary
        if ($urandom_range(3) == 0) addr[7:4] = 4'hF;
        if (cmd == CMD_WRITE) begin
            pick = $urandom_range(39);
            if (pick < 2) len = '0;
            else if (pick == 2) len = 25'($urandom_range(200, 300));
            else len = 25'($urandom_range(1, 24));
        end else if (cmd == CMD_READ) begin
            len = 25'($urandom_range(0, 12));
        end else begin
            len = 25'($urandom);
        end
        issue(ACT_COMMAND, cmd, addr, len, 8'($urandom));
    endtask

    task automatic run_random(input int count);
        int target;
        target = beats_used + count;
        while (beats_used < target || traffic.phase != PH_IDLE) begin
            if ($urandom_range(99) < 8) noise();
            else if (traffic.phase == PH_IDLE) start_command();
            else follow_up();
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (traffic.awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        logic [31:0] word;
        word       = $urandom;
        word[7:0]  = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        traffic.set_reg(idx, word);
        @(posedge aclk);
    endtask

    task automatic program_opcodes(input bit scramble, input logic [7:0] fill);
        for (int i = 0; i < 8; i++)
            write_reg(3'(i), scramble ? 8'($urandom) : fill);
        settings++;
    endtask

    initial begin
        aresetn     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        m_ready     <= 1'b0;
        s_valid     <= 1'b0;
        s_action    <= ACT_COMMAND;
        s_command   <= CMD_READ_ID;
        s_address   <= '0;
        s_length    <= '0;
        s_data_byte <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at reset opcodes
        issue(ACT_REPLY, CMD_WRITE, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF);
        issue(ACT_UNUSED, CMD_READ, 24'h000000, 25'h0000000, 8'h00);
        run_sequence(CMD_READ_ID, 24'h0, 25'h0);
        run_sequence(CMD_WRITE, 24'h123456, 25'h0);
        // crosses a page boundary and wraps the address
        run_sequence(CMD_WRITE, 24'hFFFFFF, 25'd2);
        run_sequence(CMD_SECTOR_ERASE, 24'h000000, 25'h1FFFFFF);
        run_sequence(CMD_BLOCK_ERASE, 24'hFFFFFF, 25'h0);
        run_sequence(CMD_CHIP_ERASE, 24'hA5A5A5, 25'h1000000);
        run_sequence(CMD_READ, 24'h000000, 25'h0);
        run_sequence(CMD_READ, 24'hFFFFFE, 25'd3);
        run_sequence(3'(CMD_READ + 1), 24'h5A5A5A, 25'h1FFFFFF);
        run_sequence(3'(CMD_READ + 2), 24'hFFFFFF, 25'h0);
        // a command while a sequence is in flight is dropped
        issue(ACT_COMMAND, CMD_READ_ID, 24'h0, 25'h0, 8'h00);
        issue(ACT_COMMAND, CMD_CHIP_ERASE, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF);
        complete_sequence();
        run_random(RANDOM_BEATS);
        wait_drained();

        program_opcodes(1'b0, 8'h00);
        run_random(RANDOM_BEATS);
        wait_drained();

        quiet = 1'b1;
        program_opcodes(1'b0, 8'hFF);
        run_random(RANDOM_BEATS);
        wait_drained();
        quiet = 1'b0;

        program_opcodes(1'b1, 8'h00);
        run_random(RANDOM_BEATS);
        wait_drained();

        $display("run covered %0d input beats under %0d opcode settings",
                 beats_used, settings);
        $display("%0d result beats checked", traffic.checked);
        if (traffic.failures == 0 && traffic.awaited.size() == 0) begin
            $display("PASS spi_flash_command_sequencer_top");
        end else begin
            $display("FAIL spi_flash_command_sequencer_top");
        end
        $finish;
    end

endmodule
